@@ rtl/core/mi3_pkg.sv @@
// mi3_pkg: shared constants for the 3x3 matrix inverse block
// no dependencies; used by the channel interfaces and every rtl module
`default_nettype none

package mi3_pkg;

  // default element format, signed q16.16
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // configuration register map
  localparam int unsigned REG_SINGULAR_THRESHOLD = 0;
  localparam int unsigned THR_RESET              = 1;

  localparam int unsigned NUM_ELEMS = 9;

  // cofactor c = e[k0]*e[k1] - e[k2]*e[k3], already transposed (adjugate order)
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

endpackage

`default_nettype wire

@@ rtl/core/mi3_if.sv @@
// mi3 channel interfaces: matrix request channel and result channel
// depends on mi3_pkg for the default element width
`default_nettype none

interface mi3_mat_if #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface mi3_res_if #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic signed [DATA_WIDTH-1:0] determinant;
  logic                         singular;
  logic                         saturated;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
                  determinant, singular, saturated, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
                  determinant, singular, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mi3_div_lane.sv @@
// mi3_div_lane: pipelined restoring divider, one quotient bit per stage,
// with round-half-away numerator prepared upstream and signed saturation at the end
`default_nettype none

module mi3_div_lane #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH,
  parameter int unsigned NUM_W      = 4 * mi3_pkg::DATA_WIDTH,
  parameter int unsigned DEN_W      = 3 * mi3_pkg::DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NUM_W-1:0]             num_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic                         neg_i,
  output logic signed [DATA_WIDTH-1:0] quo_o,
  output logic                         sat_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned RW = (NUM_W > DEN_W + W) ? NUM_W : DEN_W + W;

  logic [RW-1:0]    rem_q [W+1];
  logic [DEN_W-1:0] den_q [W+1];
  logic [W-1:0]     quo_q [W+1];
  logic             neg_q [W+1];
  logic             ovf_q [W+1];

  // entry stage: quotient of 2^W or more saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= (RW'(num_i) >= (RW'(den_i) << W));
    end
  end

  // one restoring step per stage, msb first
  for (genvar k = 1; k <= W; k++) begin : g_step
    localparam int unsigned B = W - k;
    logic [RW-1:0] dsh;
    logic          geq;
    assign dsh = RW'(den_q[k-1]) << B;
    assign geq = rem_q[k-1] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= geq ? rem_q[k-1] - dsh : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (W'(geq) << B);
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // sign and clip to the signed range
  logic [W-1:0] half;
  logic [W-1:0] qmag;
  assign half = W'(1) << (W - 1);
  assign qmag = quo_q[W];

  always_comb begin
    sat_o = 1'b0;
    quo_o = $signed(qmag);
    if (ovf_q[W]) begin
      sat_o = 1'b1;
      quo_o = neg_q[W] ? $signed(half) : $signed(half - W'(1));
    end else if (neg_q[W]) begin
      if (qmag > half) begin
        sat_o = 1'b1;
        quo_o = $signed(half);
      end else begin
        quo_o = $signed(W'(0) - qmag);
      end
    end else if (qmag >= half) begin
      sat_o = 1'b1;
      quo_o = $signed(half - W'(1));
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/matrix_inverse_3x3.sv @@
// matrix_inverse_3x3: pipelined 3x3 fixed-point inverse by adjugate and exact division
// depends on mi3_pkg, mi3_mat_if, mi3_res_if and mi3_div_lane
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+-------------------------------------------
//   mat_in    | in  | valid/ready      | a00..a22, signed q(W-F).F
//   res_out   | out | valid/ready      | inv00..inv22, determinant, singular, saturated
//   apb       | in  | psel/penable     | singular_threshold at byte address 0
//
// one matrix per cycle while the skid register is empty; the pipeline depth is set mostly
// by the bit-per-stage quotient pipeline of the nine divider lanes.
// all stages advance together while the output skid register is empty; a full skid
// register holds the pipe and drops mat_in.ready.
// reset clears the stage valid bits and the output and skid valid flags, and sets the
// threshold to 1.
`default_nettype none

module matrix_inverse_3x3 #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [((DATA_WIDTH > 33) ? 4 : 3)-1:0]      paddr,
  input  logic [((DATA_WIDTH > 33) ? 64 : 32)-1:0]    pwdata,
  output logic [((DATA_WIDTH > 33) ? 64 : 32)-1:0]    prdata,
  output logic                                        pready,
  mi3_mat_if.sink                                     mat_in,
  mi3_res_if.source                                   res_out
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned PAW   = (W > 33) ? 4 : 3;
  localparam int unsigned PDW   = (W > 33) ? 64 : 32;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned CW    = 2 * W + 1;
  localparam int unsigned LW    = W + 1;
  localparam int unsigned PPH   = 2 * W;
  localparam int unsigned PPL   = 2 * W + 2;
  localparam int unsigned TW    = 3 * W + 2;
  localparam int unsigned DW    = 3 * W + 4;
  localparam int unsigned TSW   = W - 1 + 2 * F;
  localparam int unsigned CMPW  = (DW > TSW) ? DW : TSW;
  localparam int unsigned NW0   = CW + 2 * F + 1;
  localparam int unsigned NW    = ((NW0 > DW) ? NW0 : DW) + 1;
  localparam int unsigned DENW  = DW + 1;
  localparam int unsigned NSTG  = 7 + W + 1;
  localparam int unsigned RESW  = 10 * W + 2;

  // ---------------------------------------------------------------- config port
  logic [W-2:0] thr_q, thr_d;
  logic         reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PAW-1] == 1'(mi3_pkg::REG_SINGULAR_THRESHOLD));
  assign prdata  = reg_hit ? PDW'(thr_q) : '0;

  // threshold write on the access cycle
  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      thr_d = pwdata[W-2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= (W-1)'(mi3_pkg::THR_RESET);
    end else begin
      thr_q <= thr_d;
    end
  end

  // ---------------------------------------------------------------- flow control
  logic              en;
  logic              skid_valid_q, skid_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [RESW-1:0]   skid_q, skid_d, out_q, out_d, fin;
  logic [NSTG-1:0]   v_q;

  assign en           = !skid_valid_q;
  assign mat_in.ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], mat_in.valid};
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic signed [W-1:0]  e_in [9];
  logic signed [PW-1:0] prod_q [18];
  logic signed [W-1:0]  row_q [3];

  assign e_in[0] = mat_in.a00;
  assign e_in[1] = mat_in.a01;
  assign e_in[2] = mat_in.a02;
  assign e_in[3] = mat_in.a10;
  assign e_in[4] = mat_in.a11;
  assign e_in[5] = mat_in.a12;
  assign e_in[6] = mat_in.a20;
  assign e_in[7] = mat_in.a21;
  assign e_in[8] = mat_in.a22;

  for (genvar i = 0; i < 9; i++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[2*i]   <= e_in[mi3_pkg::COF_IDX[i][0]] * e_in[mi3_pkg::COF_IDX[i][1]];
        prod_q[2*i+1] <= e_in[mi3_pkg::COF_IDX[i][2]] * e_in[mi3_pkg::COF_IDX[i][3]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row_q[0] <= e_in[0];
      row_q[1] <= e_in[1];
      row_q[2] <= e_in[2];
    end
  end

  // ---------------------------------------------------------------- stage 2: cofactors
  logic signed [CW-1:0] cof2_q [9];
  logic signed [W-1:0]  row2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        cof2_q[i] <= CW'(prod_q[2*i]) - CW'(prod_q[2*i+1]);
      end
      for (int j = 0; j < 3; j++) begin
        row2_q[j] <= row_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: split products
  // first-row expansion uses adjugate entries 0, 3 and 6
  logic signed [PPH-1:0] pph_q [3];
  logic signed [PPL-1:0] ppl_q [3];
  logic signed [CW-1:0]  cof3_q [9];

  for (genvar j = 0; j < 3; j++) begin : g_split
    logic signed [W-1:0]   hi;
    logic signed [W+1:0]   lo;
    assign hi = $signed(cof2_q[3*j][CW-1:LW]);
    assign lo = $signed({1'b0, cof2_q[3*j][LW-1:0]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        pph_q[j] <= row2_q[j] * hi;
        ppl_q[j] <= row2_q[j] * lo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cof3_q <= cof2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: join halves
  logic signed [TW-1:0] term_q [3];
  logic signed [CW-1:0] cof4_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        term_q[j] <= (TW'(pph_q[j]) <<< LW) + TW'(ppl_q[j]);
      end
      cof4_q <= cof3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: determinant
  logic signed [DW-1:0] det_q;
  logic signed [CW-1:0] cof5_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q  <= DW'(term_q[0]) + DW'(term_q[1]) + DW'(term_q[2]);
      cof5_q <= cof4_q;
    end
  end

  // ---------------------------------------------------------------- stage 6: magnitudes
  logic [DW-1:0] dmag_q;
  logic          dneg_q;
  logic [CW-1:0] cmag_q [9];
  logic          cneg_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q <= det_q[DW-1];
      dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      for (int i = 0; i < 9; i++) begin
        cneg_q[i] <= cof5_q[i][CW-1];
        cmag_q[i] <= cof5_q[i][CW-1] ? CW'(-cof5_q[i]) : CW'(cof5_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 7: divider operands
  logic [NW-1:0]       num_q [9];
  logic                qneg_q [9];
  logic [DENW-1:0]     den_q;
  logic                sing_q;
  logic signed [W-1:0] detv_q;
  logic                dsat_q;

  logic [DW-1:0]       drnd;
  logic [DW-1:0]       dlim;
  logic signed [W-1:0] detv_d;
  logic                dsat_d;
  logic                sing_d;

  // determinant rounded half away from zero, then clipped
  assign drnd = (dmag_q + (DW'(1) << (2 * F - 1))) >> (2 * F);
  assign dlim = DW'(1) << (W - 1);

  always_comb begin
    dsat_d = 1'b0;
    detv_d = $signed(drnd[W-1:0]);
    if (dneg_q) begin
      if (drnd > dlim) begin
        dsat_d = 1'b1;
        detv_d = $signed(W'(1) << (W - 1));
      end else begin
        detv_d = $signed(W'(0) - drnd[W-1:0]);
      end
    end else if (drnd >= dlim) begin
      dsat_d = 1'b1;
      detv_d = $signed((W'(1) << (W - 1)) - W'(1));
    end
  end

  assign sing_d = (dmag_q == '0) || (CMPW'(dmag_q) < (CMPW'(thr_q) << (2 * F)));

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        num_q[i]  <= (NW'(cmag_q[i]) << (2 * F + 1)) + NW'(dmag_q);
        qneg_q[i] <= cneg_q[i] ^ dneg_q;
      end
      den_q  <= DENW'(dmag_q) << 1;
      sing_q <= sing_d;
      detv_q <= detv_d;
      dsat_q <= dsat_d;
    end
  end

  // ---------------------------------------------------------------- divider lanes
  logic signed [W-1:0] quo [9];
  logic                qsat [9];

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div_lane #(
      .DATA_WIDTH (W),
      .NUM_W      (NW),
      .DEN_W      (DENW)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[i]),
      .den_i (den_q),
      .neg_i (qneg_q[i]),
      .quo_o (quo[i]),
      .sat_o (qsat[i])
    );
  end

  // side data delayed to match the lanes
  logic                sing_s_q [W+1];
  logic signed [W-1:0] detv_s_q [W+1];
  logic                dsat_s_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_s_q[0] <= sing_q;
      detv_s_q[0] <= detv_q;
      dsat_s_q[0] <= dsat_q;
      for (int k = 1; k <= W; k++) begin
        sing_s_q[k] <= sing_s_q[k-1];
        detv_s_q[k] <= detv_s_q[k-1];
        dsat_s_q[k] <= dsat_s_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- final result
  logic [9*W-1:0] inv_flat;
  logic           any_qsat;

  always_comb begin
    inv_flat = '0;
    any_qsat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      inv_flat[i*W +: W] = sing_s_q[W] ? '0 : quo[i];
      any_qsat           = any_qsat | qsat[i];
    end
  end

  assign fin = {dsat_s_q[W] | (!sing_s_q[W] & any_qsat), sing_s_q[W], detv_s_q[W], inv_flat};

  // output register with skid stage
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || res_out.ready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = fin;
        out_valid_d = v_q[NSTG-1];
      end
    end else if (en && v_q[NSTG-1]) begin
      skid_d       = fin;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_out.valid       = out_valid_q;
  assign res_out.inv00       = out_q[0*W +: W];
  assign res_out.inv01       = out_q[1*W +: W];
  assign res_out.inv02       = out_q[2*W +: W];
  assign res_out.inv10       = out_q[3*W +: W];
  assign res_out.inv11       = out_q[4*W +: W];
  assign res_out.inv12       = out_q[5*W +: W];
  assign res_out.inv20       = out_q[6*W +: W];
  assign res_out.inv21       = out_q[7*W +: W];
  assign res_out.inv22       = out_q[8*W +: W];
  assign res_out.determinant = out_q[9*W +: W];
  assign res_out.singular    = out_q[10*W];
  assign res_out.saturated   = out_q[10*W+1];

  // ---------------------------------------------------------------- assertions
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a request while the output register is empty");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && res_out.singular) |->
      (res_out.inv00 == '0 && res_out.inv11 == '0 && res_out.inv22 == '0 &&
       res_out.inv01 == '0 && res_out.inv12 == '0 && res_out.inv20 == '0))
    else $error("singular result carries a nonzero inverse element");

  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> v_q == $past(v_q))
    else $error("pipeline moved while the skid register was full");

  a_fill_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !res_out.ready && v_q[NSTG-1]))
    else $error("skid register filled without a stalled output");

endmodule

`default_nettype wire
